// ===== rtl/nbp_pkg.sv =====
package nbp_pkg;

  // Field widths of one event and one result
  localparam int FUNC_W   = 2;
  localparam int ANCHOR_W = 12;
  localparam int TIME_W   = 64;
  localparam int HITS_W   = 32;
  localparam int STATUS_W = 2;

  // Packed stream widths, padded to whole bytes
  localparam int IN_USED_W   = FUNC_W + ANCHOR_W + TIME_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W  = STATUS_W + 3 * TIME_W + HITS_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  // Event codes
  localparam logic [FUNC_W-1:0] FUNC_ENTER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXIT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  // One anchor's counters, as held in the table memory
  typedef struct packed {
    logic [HITS_W-1:0] hits;
    logic [TIME_W-1:0] children;
    logic [TIME_W-1:0] inclusive;
  } tbl_ent_t;

  localparam int TBL_ENT_W = $bits(tbl_ent_t);

endpackage

// ===== rtl/nbp_ram.sv =====
module nbp_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; a same-address write returns the old data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/nested_block_profiler.sv =====
// Steps: enter and read go through anchor reduction, memory access and result, as do unused
//   codes; exit goes through stack read, then read-modify-write of the anchor and its parent.
// One event at a time: in_tready is low until the result enters the output register,
//   which waits for the previous result to go; exit passes through the counter table twice.
// Reset: synchronous, active low. Afterwards the counter table is cleared one entry a cycle,
//   with in_tready low; the nesting stack is empty and the parent is root.
module nested_block_profiler #(
  parameter int ANCHOR_COUNT = 4096,
  parameter int NEST_DEPTH   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // func[1:0], anchor[13:2], timestamp[77:14], zero pad
  input  logic [nbp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[1:0], inclusive_time[65:2], children_time[129:66],
  // exclusive_time[193:130], hits[225:194], zero pad
  output logic [nbp_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int SLOT_W = $clog2(ANCHOR_COUNT);
  localparam int LVL_W  = $clog2(NEST_DEPTH + 1);
  localparam int SP_W   = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int STK_W  = 2 * SLOT_W + nbp_pkg::TIME_W;

  // Anchor modulo ANCHOR_COUNT by reciprocal multiply and one correction
  localparam int RCP_SH = 24;
  localparam int PROD_W = nbp_pkg::ANCHOR_W + RCP_SH;
  localparam int RED_W  = nbp_pkg::ANCHOR_W + 18;
  localparam logic [RCP_SH-1:0] RCP   = RCP_SH'((1 << RCP_SH) / ANCHOR_COUNT);
  localparam logic [RED_W-1:0]  CNT_R = RED_W'(ANCHOR_COUNT);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MOD, S_DISP, S_POP, S_WHO, S_UP, S_OUT
  } state_t;

  state_t                               state_r, state_nxt;
  logic [LVL_W-1:0]                     level_r, level_nxt;
  logic [SLOT_W-1:0]                    parent_r, parent_nxt;
  logic [SLOT_W-1:0]                    clr_r, clr_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [nbp_pkg::OUT_TDATA_W-1:0]      out_data_r, out_data_nxt;
  logic [nbp_pkg::FUNC_W-1:0]           func_r, func_nxt;
  logic [nbp_pkg::ANCHOR_W-1:0]         anchor_r, anchor_nxt;
  logic [nbp_pkg::TIME_W-1:0]           time_r, time_nxt;
  logic [nbp_pkg::ANCHOR_W-1:0]         quo_r, quo_nxt;
  logic [SLOT_W-1:0]                    who_r, who_nxt;
  logic [SLOT_W-1:0]                    up_r, up_nxt;
  logic [nbp_pkg::TIME_W-1:0]           elapsed_r, elapsed_nxt;
  nbp_pkg::tbl_ent_t                    fwd_r, fwd_nxt;
  logic [nbp_pkg::STATUS_W-1:0]         status_r, status_nxt;

  // Memory ports
  logic                  tbl_we, tbl_re;
  logic [SLOT_W-1:0]     tbl_wa, tbl_ra;
  nbp_pkg::tbl_ent_t     tbl_wd, tbl_q;
  logic                  stk_we, stk_re;
  logic [SP_W-1:0]       stk_wa, stk_ra;
  logic [STK_W-1:0]      stk_wd, stk_q;

  // Slot reduction datapath
  logic [PROD_W-1:0]     prod_w;
  logic [RED_W-1:0]      qn_w, rem_w;
  logic [SLOT_W-1:0]     slot_w;
  logic [LVL_W-1:0]      lvl_dec_w;
  logic                  out_free_w;

  // Fields of the stack top
  logic [SLOT_W-1:0]            stk_parent_w, stk_anchor_w;
  logic [nbp_pkg::TIME_W-1:0]   stk_start_w;

  // Working copies of table entries
  nbp_pkg::tbl_ent_t     who_ent_w, up_ent_w;
  logic [nbp_pkg::TIME_W-1:0] excl_w;

  nbp_ram #(
    .DEPTH  (ANCHOR_COUNT),
    .ADDR_W (SLOT_W),
    .DATA_W (nbp_pkg::TBL_ENT_W)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_wa),
    .wr_data (tbl_wd),
    .rd_en   (tbl_re),
    .rd_addr (tbl_ra),
    .rd_data (tbl_q)
  );

  nbp_ram #(
    .DEPTH  (NEST_DEPTH),
    .ADDR_W (SP_W),
    .DATA_W (STK_W)
  ) u_stk (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_wa),
    .wr_data (stk_wd),
    .rd_en   (stk_re),
    .rd_addr (stk_ra),
    .rd_data (stk_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free_w = !out_valid_r || out_tready;

  // Quotient estimate, registered in S_MOD
  assign prod_w = PROD_W'(anchor_r) * PROD_W'(RCP);
  // Remainder lands below twice the count
  assign qn_w   = RED_W'(quo_r) * CNT_R;
  assign rem_w  = RED_W'(anchor_r) - qn_w;
  assign slot_w = (rem_w >= CNT_R) ? SLOT_W'(rem_w - CNT_R) : SLOT_W'(rem_w);

  assign lvl_dec_w = level_r - LVL_W'(1);

  assign stk_start_w  = stk_q[nbp_pkg::TIME_W-1:0];
  assign stk_anchor_w = stk_q[nbp_pkg::TIME_W +: SLOT_W];
  assign stk_parent_w = stk_q[nbp_pkg::TIME_W + SLOT_W +: SLOT_W];

  assign excl_w = tbl_q.inclusive - tbl_q.children;

  // Anchor update: inclusive time and saturating hit count
  always_comb begin
    who_ent_w = tbl_q;
    who_ent_w.inclusive = tbl_q.inclusive + elapsed_r;
    if (tbl_q.hits != nbp_pkg::HITS_MAX) begin
      who_ent_w.hits = tbl_q.hits + nbp_pkg::HITS_W'(1);
    end
  end

  // Parent update, forwarded when the parent is the anchor just written
  always_comb begin
    up_ent_w = (up_r == who_r) ? fwd_r : tbl_q;
    up_ent_w.children = up_ent_w.children + elapsed_r;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    parent_nxt    = parent_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    func_nxt      = func_r;
    anchor_nxt    = anchor_r;
    time_nxt      = time_r;
    quo_nxt       = quo_r;
    who_nxt       = who_r;
    up_nxt        = up_r;
    elapsed_nxt   = elapsed_r;
    fwd_nxt       = fwd_r;
    status_nxt    = status_r;
    tbl_we = 1'b0;
    tbl_wa = '0;
    tbl_wd = '0;
    tbl_re = 1'b0;
    tbl_ra = '0;
    stk_we = 1'b0;
    stk_wa = '0;
    stk_wd = '0;
    stk_re = 1'b0;
    stk_ra = '0;

    // Output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        tbl_we = 1'b1;
        tbl_wa = clr_r;
        if (clr_r == SLOT_W'(ANCHOR_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + SLOT_W'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt   = in_tdata[nbp_pkg::FUNC_W-1:0];
          anchor_nxt = in_tdata[nbp_pkg::FUNC_W +: nbp_pkg::ANCHOR_W];
          time_nxt   = in_tdata[nbp_pkg::FUNC_W + nbp_pkg::ANCHOR_W +: nbp_pkg::TIME_W];
          // exit needs no anchor slot
          state_nxt  = (in_tdata[nbp_pkg::FUNC_W-1:0] == nbp_pkg::FUNC_EXIT) ? S_DISP : S_MOD;
        end
      end
      S_MOD: begin
        quo_nxt   = prod_w[PROD_W-1:RCP_SH];
        state_nxt = S_DISP;
      end
      S_DISP: begin
        status_nxt = nbp_pkg::STATUS_OK;
        state_nxt  = S_OUT;
        unique case (func_r)
          nbp_pkg::FUNC_ENTER: begin
            if (level_r == LVL_W'(NEST_DEPTH)) begin
              status_nxt = nbp_pkg::STATUS_OVERFLOW;
            end else begin
              stk_we     = 1'b1;
              stk_wa     = level_r[SP_W-1:0];
              stk_wd     = {parent_r, slot_w, time_r};
              level_nxt  = level_r + LVL_W'(1);
              parent_nxt = slot_w;
            end
          end
          nbp_pkg::FUNC_EXIT: begin
            if (level_r == '0) begin
              status_nxt = nbp_pkg::STATUS_UNDERFLOW;
            end else begin
              stk_re    = 1'b1;
              stk_ra    = lvl_dec_w[SP_W-1:0];
              level_nxt = lvl_dec_w;
              state_nxt = S_POP;
            end
          end
          nbp_pkg::FUNC_READ: begin
            tbl_re = 1'b1;
            tbl_ra = slot_w;
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        who_nxt     = stk_anchor_w;
        up_nxt      = stk_parent_w;
        parent_nxt  = stk_parent_w;
        elapsed_nxt = time_r - stk_start_w;
        tbl_re      = 1'b1;
        tbl_ra      = stk_anchor_w;
        state_nxt   = S_WHO;
      end
      S_WHO: begin
        tbl_we    = 1'b1;
        tbl_wa    = who_r;
        tbl_wd    = who_ent_w;
        fwd_nxt   = who_ent_w;
        tbl_re    = 1'b1;
        tbl_ra    = up_r;
        state_nxt = S_UP;
      end
      S_UP: begin
        tbl_we    = 1'b1;
        tbl_wa    = up_r;
        tbl_wd    = up_ent_w;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free_w) begin
          out_valid_nxt = 1'b1;
          if (func_r == nbp_pkg::FUNC_READ) begin
            out_data_nxt = {{nbp_pkg::OUT_PAD_W{1'b0}}, tbl_q.hits, excl_w,
                            tbl_q.children, tbl_q.inclusive, status_r};
          end else begin
            out_data_nxt = {{(nbp_pkg::OUT_TDATA_W - nbp_pkg::STATUS_W){1'b0}}, status_r};
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      level_r     <= '0;
      parent_r    <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      parent_r    <= parent_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    func_r     <= func_nxt;
    anchor_r   <= anchor_nxt;
    time_r     <= time_nxt;
    quo_r      <= quo_nxt;
    who_r      <= who_nxt;
    up_r       <= up_nxt;
    elapsed_r  <= elapsed_nxt;
    fwd_r      <= fwd_nxt;
    status_r   <= status_nxt;
  end

`ifndef SYNTH
  // Nesting level moves by at most one per cycle
  a_lvl_step: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r != $past(level_r)) |->
      ((level_r == $past(level_r) + LVL_W'(1)) || (level_r == $past(level_r) - LVL_W'(1))))
    else $error("stack level jumped");

  // Nesting level stays within the stack depth
  a_lvl_max: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(NEST_DEPTH))
    else $error("stack level beyond depth");

  // One event in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted while busy");

  // A result appears only out of the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside output state");
`endif

endmodule

// ===== bench/nested_block_profiler_tb.sv =====
`timescale 1ns / 100ps

module nested_block_profiler_tb;

  localparam int NUM_ANCHORS   = 4096;
  localparam int MAX_NESTING   = 64;
  localparam int SP_BITS       = $clog2(MAX_NESTING);
  localparam int RANDOM_EVENTS = 250;
  localparam int CALM_EVENTS   = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int PRINT_LIMIT   = 60;
  localparam int N_ROWS        = 25;

  // Unused event code, accepted and answered with an all-zero result
  localparam logic [nbp_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

  // One profiler answer, field by field
  typedef struct packed {
    logic [nbp_pkg::STATUS_W-1:0] status;
    logic [nbp_pkg::TIME_W-1:0]   incl;
    logic [nbp_pkg::TIME_W-1:0]   kids;
    logic [nbp_pkg::TIME_W-1:0]   excl;
    logic [nbp_pkg::HITS_W-1:0]   hits;
  } profile_result_t;

  // Directed stimulus row; typed rows carry a hand-written status with zero times
  typedef struct packed {
    logic [nbp_pkg::FUNC_W-1:0]   func;
    logic [nbp_pkg::ANCHOR_W-1:0] anchor;
    logic [nbp_pkg::TIME_W-1:0]   ts;
    logic [7:0]                   reps;
    logic                         typed;
    logic [nbp_pkg::STATUS_W-1:0] want;
  } step_row_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [nbp_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [nbp_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Predictor state
  bit [nbp_pkg::TIME_W-1:0]   incl_tbl [NUM_ANCHORS];
  bit [nbp_pkg::TIME_W-1:0]   kids_tbl [NUM_ANCHORS];
  bit [nbp_pkg::HITS_W-1:0]   hit_tbl  [NUM_ANCHORS];
  bit [nbp_pkg::ANCHOR_W-1:0] cur_parent;
  bit [nbp_pkg::ANCHOR_W-1:0] parent_stk [MAX_NESTING];
  bit [nbp_pkg::ANCHOR_W-1:0] anchor_stk [MAX_NESTING];
  bit [nbp_pkg::TIME_W-1:0]   start_stk  [MAX_NESTING];
  int                         nest_level;

  profile_result_t due_results [$];
  int              err_count;
  int              cycle_count;
  int              send_idle_pct = 20;
  bit              calm;
  bit              hold_req;

  step_row_t script [N_ROWS] = '{
    '{nbp_pkg::FUNC_READ, 12'd0, 64'd0, 8'd1, 1'b1, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_READ, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_EXIT, 12'd0, 64'd5, 8'd1, 1'b1, nbp_pkg::STATUS_UNDERFLOW},
    '{FUNC_SPARE, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b1, nbp_pkg::STATUS_OK},
    // nested blocks with anchor 7 re-entered inside itself
    '{nbp_pkg::FUNC_ENTER, 12'd7,    64'd100,  8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_ENTER, 12'd4095, 64'd150,  8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_ENTER, 12'd7,    64'd160,  8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_EXIT,  12'd0,    64'd200,  8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_EXIT,  12'd4095, 64'd260,  8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_EXIT,  12'd0,    64'd1000, 8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_READ,  12'd7,    64'd0,    8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_READ,  12'd4095, 64'd0,    8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_READ,  12'd0,    64'd0,    8'd1, 1'b0, nbp_pkg::STATUS_OK},
    // timestamp wraps between enter and exit
    '{nbp_pkg::FUNC_ENTER, 12'd12, 64'hFFFF_FFFF_FFFF_FFF0, 8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_EXIT,  12'd0,  64'd16, 8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_READ,  12'd12, 64'd0,  8'd1, 1'b0, nbp_pkg::STATUS_OK},
    // fill the stack, overflow once, drain it, underflow once
    '{nbp_pkg::FUNC_ENTER, 12'd1, 64'd2000, 8'd64, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_ENTER, 12'd2, 64'd2100, 8'd1,  1'b1, nbp_pkg::STATUS_OVERFLOW},
    '{nbp_pkg::FUNC_EXIT,  12'd0, 64'd2500, 8'd64, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_EXIT,  12'd0, 64'd2600, 8'd1,  1'b1, nbp_pkg::STATUS_UNDERFLOW},
    '{nbp_pkg::FUNC_READ,  12'd1, 64'd0,    8'd1,  1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_READ,  12'd0, 64'd0,    8'd1,  1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_ENTER, 12'd2048, 64'h5555_5555_5555_5555, 8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_EXIT,  12'd0,    64'hAAAA_AAAA_AAAA_AAAA, 8'd1, 1'b0, nbp_pkg::STATUS_OK},
    '{nbp_pkg::FUNC_READ,  12'd2048, 64'd0, 8'd1, 1'b0, nbp_pkg::STATUS_OK}
  };

  logic [nbp_pkg::ANCHOR_W-1:0] hot_anchor [8] = '{12'd0, 12'd1, 12'd5, 12'd77,
                                                   12'd300, 12'd2048, 12'd3000, 12'd4095};

  nested_block_profiler u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Profiler behavior for one event, updating the predictor state
  function automatic profile_result_t profile_step(input logic [nbp_pkg::FUNC_W-1:0] f,
                                                   input logic [nbp_pkg::ANCHOR_W-1:0] a,
                                                   input logic [nbp_pkg::TIME_W-1:0] ts);
    profile_result_t              r;
    logic [nbp_pkg::TIME_W-1:0]   spent;
    logic [nbp_pkg::ANCHOR_W-1:0] who;
    logic [nbp_pkg::ANCHOR_W-1:0] up;
    logic [SP_BITS-1:0]           sp;
    r = '0;
    case (f)
      nbp_pkg::FUNC_ENTER: begin
        if (nest_level >= MAX_NESTING) begin
          r.status = nbp_pkg::STATUS_OVERFLOW;
        end else begin
          sp = SP_BITS'(nest_level);
          parent_stk[sp] = cur_parent;
          anchor_stk[sp] = a;
          start_stk[sp]  = ts;
          nest_level++;
          cur_parent = a;
        end
      end
      nbp_pkg::FUNC_EXIT: begin
        if (nest_level == 0) begin
          r.status = nbp_pkg::STATUS_UNDERFLOW;
        end else begin
          nest_level--;
          sp    = SP_BITS'(nest_level);
          who   = anchor_stk[sp];
          up    = parent_stk[sp];
          spent = ts - start_stk[sp];
          cur_parent    = up;
          kids_tbl[up]  += spent;
          incl_tbl[who] += spent;
          if (hit_tbl[who] != nbp_pkg::HITS_MAX) hit_tbl[who]++;
        end
      end
      nbp_pkg::FUNC_READ: begin
        r.incl = incl_tbl[a];
        r.kids = kids_tbl[a];
        r.excl = incl_tbl[a] - kids_tbl[a];
        r.hits = hit_tbl[a];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [nbp_pkg::TIME_W-1:0] got,
                                 input logic [nbp_pkg::TIME_W-1:0] want);
    if (err_count < PRINT_LIMIT)
      $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // Offer one event, wait for its transaction, then queue the expected answer
  task automatic drive_event(input logic [nbp_pkg::FUNC_W-1:0] f,
                             input logic [nbp_pkg::ANCHOR_W-1:0] a,
                             input logic [nbp_pkg::TIME_W-1:0] ts, input logic typed,
                             input logic [nbp_pkg::STATUS_W-1:0] want);
    logic [nbp_pkg::IN_TDATA_W-1:0] word;
    profile_result_t                r;
    int                             gap;
    word = '0;
    word[nbp_pkg::FUNC_W-1:0]                                    = f;
    word[nbp_pkg::FUNC_W +: nbp_pkg::ANCHOR_W]                   = a;
    word[nbp_pkg::FUNC_W + nbp_pkg::ANCHOR_W +: nbp_pkg::TIME_W] = ts;
    gap = (!calm && $urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    r = profile_step(f, a, ts);
    if (typed) begin
      r = '0;
      r.status = want;
    end
    due_results.push_back(r);
  endtask

  // Result checker
  always @(posedge clk) begin
    profile_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result",
                        nbp_pkg::TIME_W'(out_tdata[nbp_pkg::STATUS_W-1:0]), '0);
      end else begin
        want = due_results.pop_front();
        if (out_tdata[nbp_pkg::STATUS_W-1:0] !== want.status)
          report_mismatch("status", nbp_pkg::TIME_W'(out_tdata[nbp_pkg::STATUS_W-1:0]),
                          nbp_pkg::TIME_W'(want.status));
        if (out_tdata[nbp_pkg::STATUS_W +: nbp_pkg::TIME_W] !== want.incl)
          report_mismatch("inclusive_time", out_tdata[nbp_pkg::STATUS_W +: nbp_pkg::TIME_W],
                          want.incl);
        if (out_tdata[nbp_pkg::STATUS_W + nbp_pkg::TIME_W +: nbp_pkg::TIME_W] !== want.kids)
          report_mismatch("children_time",
                          out_tdata[nbp_pkg::STATUS_W + nbp_pkg::TIME_W +: nbp_pkg::TIME_W],
                          want.kids);
        if (out_tdata[nbp_pkg::STATUS_W + 2*nbp_pkg::TIME_W +: nbp_pkg::TIME_W] !== want.excl)
          report_mismatch("exclusive_time",
                          out_tdata[nbp_pkg::STATUS_W + 2*nbp_pkg::TIME_W +: nbp_pkg::TIME_W],
                          want.excl);
        if (out_tdata[nbp_pkg::STATUS_W + 3*nbp_pkg::TIME_W +: nbp_pkg::HITS_W] !== want.hits)
          report_mismatch("hits", nbp_pkg::TIME_W'(
                            out_tdata[nbp_pkg::STATUS_W + 3*nbp_pkg::TIME_W +: nbp_pkg::HITS_W]),
                          nbp_pkg::TIME_W'(want.hits));
        if (out_tdata[nbp_pkg::OUT_TDATA_W-1 -: nbp_pkg::OUT_PAD_W] !== '0)
          report_mismatch("pad", nbp_pkg::TIME_W'(
                            out_tdata[nbp_pkg::OUT_TDATA_W-1 -: nbp_pkg::OUT_PAD_W]), '0);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin
    int recv_idle_pct;
    int tick;
    int gap;
    bit held;
    recv_idle_pct = 15;
    tick = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 64 == 0) recv_idle_pct = 25 * $urandom_range(0, 2);
      if (hold_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
        gap = $urandom_range(1, 13);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Sender: reset, directed table, then random nesting traffic
  initial begin
    logic [nbp_pkg::FUNC_W-1:0]   f;
    logic [nbp_pkg::ANCHOR_W-1:0] a;
    logic [nbp_pkg::TIME_W-1:0]   ts;
    logic [nbp_pkg::TIME_W-1:0]   clock_now;
    int                           roll;
    int                           enter_pct;
    int                           dive_left;
    int                           k;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      for (int j = 0; j < script[i].reps; j++)
        drive_event(script[i].func, script[i].anchor, script[i].ts, script[i].typed,
                    script[i].want);
    end

    clock_now = {$urandom, $urandom};
    dive_left = 0;
    for (k = 0; k < RANDOM_EVENTS; k++) begin
      if (k == 60) hold_req = 1'b1;
      if (k == RANDOM_EVENTS - CALM_EVENTS) calm = 1'b1;
      if (k % 40 == 0) send_idle_pct = 25 * $urandom_range(0, 2);
      if (dive_left == 0 && $urandom_range(0, 149) == 0) dive_left = 70;

      // mostly a running cycle counter, now and then a jump so elapsed wraps
      if ($urandom_range(0, 29) == 0) clock_now = {$urandom, $urandom};
      else clock_now += nbp_pkg::TIME_W'($urandom_range(1, 2000));
      ts = clock_now;

      a = hot_anchor[3'($urandom_range(0, 7))];
      if ($urandom_range(0, 7) == 0) a = nbp_pkg::ANCHOR_W'($urandom_range(0, NUM_ANCHORS - 1));

      // keep the stack from sitting at full once it gets deep
      enter_pct = (nest_level > 48) ? 25 : 40;
      roll = $urandom_range(0, 99);
      if (dive_left != 0) begin
        f = nbp_pkg::FUNC_ENTER;
        dive_left--;
      end else if (roll < enter_pct) begin
        f = nbp_pkg::FUNC_ENTER;
      end else if (roll < 74) begin
        f = nbp_pkg::FUNC_EXIT;
        a = nbp_pkg::ANCHOR_W'($urandom_range(0, NUM_ANCHORS - 1));
      end else if (roll < 94) begin
        f = nbp_pkg::FUNC_READ;
      end else begin
        // noise: any code, any anchor, any timestamp
        f  = (roll < 97) ? FUNC_SPARE : nbp_pkg::FUNC_W'($urandom_range(0, 3));
        a  = nbp_pkg::ANCHOR_W'($urandom_range(0, NUM_ANCHORS - 1));
        ts = {$urandom, $urandom};
      end
      drive_event(f, a, ts, 1'b0, nbp_pkg::STATUS_OK);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
